// File: design/rcf_pkg.sv
// ----------------------------------------------------------------------------
// rcf_pkg
// Shared constants and result type for the request command framer.
// ----------------------------------------------------------------------------
`default_nettype none

package rcf_pkg;

    localparam int unsigned ARG_COUNT_CAP   = 1048576;
    localparam int unsigned BULK_LENGTH_CAP = 536870912;

    localparam int ARG_LIMIT_W  = 21;
    localparam int BULK_LIMIT_W = 30;
    localparam int NUM_W        = 64;

    localparam logic [ARG_LIMIT_W-1:0]  ARG_LIMIT_RESET  = ARG_LIMIT_W'(ARG_COUNT_CAP);
    localparam logic [BULK_LIMIT_W-1:0] BULK_LIMIT_RESET = BULK_LIMIT_W'(BULK_LENGTH_CAP);
    localparam logic [NUM_W-1:0]        MAG_LIMIT        = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [2:0] ERR_NONE        = 3'd0;
    localparam logic [2:0] ERR_TYPE        = 3'd1;
    localparam logic [2:0] ERR_NUMBER      = 3'd2;
    localparam logic [2:0] ERR_COUNT_RANGE = 3'd3;
    localparam logic [2:0] ERR_BULK_LONG   = 3'd4;
    localparam logic [2:0] ERR_NO_CRLF     = 3'd5;

    localparam logic [0:0] CFG_ARG_LIMIT  = 1'b0;
    localparam logic [0:0] CFG_BULK_LIMIT = 1'b1;

    typedef struct packed {
        logic [7:0] arg_byte;
        logic       byte_valid;
        logic       arg_end;
        logic       command_done;
        logic [2:0] error_code;
        logic       last_of_run;
    } result_t;

endpackage

`default_nettype wire

// File: design/resp_command_framer_top.sv
// ----------------------------------------------------------------------------
// resp_command_framer_top
// Byte-serial framer that splits array commands into argument words.
// Results: each result word is queued when its input byte is taken.
// Throughput: one input byte per cycle while the queue holds two or fewer words;
// a byte yielding two results is absorbed by the four-entry result queue.
// Reset: parser waits for '*', limits return to their caps, queue empties.
// ----------------------------------------------------------------------------
`default_nettype none

module resp_command_framer_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  in_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       arg_byte,
    output logic             byte_valid,
    output logic             arg_end,
    output logic             command_done,
    output logic [2:0]       error_code,
    output logic             last_of_run,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [29:0] cfg_data
);

    typedef enum logic [3:0] {
        PH_STAR,
        PH_HNUM,
        PH_HLF,
        PH_TYPE,
        PH_BNUM,
        PH_BLF,
        PH_PAY,
        PH_PCR,
        PH_PLF,
        PH_TEXT
    } phase_t;

    phase_t                                phase_reg, phase_next;
    logic [rcf_pkg::ARG_LIMIT_W-1:0]       arg_limit_reg;
    logic [rcf_pkg::BULK_LIMIT_W-1:0]      bulk_limit_reg;
    logic [rcf_pkg::ARG_LIMIT_W-1:0]       args_left_reg, args_left_next;
    logic [rcf_pkg::BULK_LIMIT_W-1:0]      payload_left_reg, payload_left_next;
    logic [rcf_pkg::NUM_W-1:0]             num_value_reg, num_value_next;
    logic                                  num_neg_reg, num_neg_next;
    logic                                  num_ovf_reg, num_ovf_next;
    logic                                  digit_seen_reg, digit_seen_next;
    logic                                  lead_zero_reg, lead_zero_next;
    logic                                  cr_pending_reg, cr_pending_next;

    rcf_pkg::result_t                      queue_mem [4];
    logic [1:0]                            wr_ptr_reg, rd_ptr_reg;
    logic [2:0]                            count_reg;

    rcf_pkg::result_t                      res0, res1;
    logic [1:0]                            res_count;

    logic                                  in_fire, out_fire;
    logic                                  is_digit, is_minus;
    logic [3:0]                            digit;
    logic [67:0]                           num_prod;
    logic                                  num_ok;
    logic                                  upd_neg, upd_ovf, upd_lead;
    logic [rcf_pkg::NUM_W-1:0]             upd_value;
    logic                                  num_good;
    logic [rcf_pkg::ARG_LIMIT_W-1:0]       arg_lim;
    logic [rcf_pkg::BULK_LIMIT_W-1:0]      bulk_lim;
    logic [rcf_pkg::ARG_LIMIT_W-1:0]       args_dec;
    logic [rcf_pkg::BULK_LIMIT_W-1:0]      payload_dec;
    logic                                  do_fail, do_finish, do_clear_num;
    logic [2:0]                            fail_code;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign in_ready  = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);
    assign cfg_ready = 1'b1;

    assign arg_byte     = queue_mem[rd_ptr_reg].arg_byte;
    assign byte_valid   = queue_mem[rd_ptr_reg].byte_valid;
    assign arg_end      = queue_mem[rd_ptr_reg].arg_end;
    assign command_done = queue_mem[rd_ptr_reg].command_done;
    assign error_code   = queue_mem[rd_ptr_reg].error_code;
    assign last_of_run  = queue_mem[rd_ptr_reg].last_of_run;

    // number accumulation for one byte
    assign is_digit = (in_byte >= rcf_pkg::CH_ZERO) && (in_byte <= rcf_pkg::CH_NINE);
    assign is_minus = (in_byte == rcf_pkg::CH_MINUS);
    assign digit    = in_byte[3:0];
    assign num_prod = {1'b0, num_value_reg, 3'b000} + {3'b000, num_value_reg, 1'b0}
                    + {64'd0, digit};

    always_comb
    begin
        num_ok    = 1'b0;
        upd_neg   = num_neg_reg;
        upd_ovf   = num_ovf_reg;
        upd_lead  = lead_zero_reg;
        upd_value = num_value_reg;
        if (is_minus)
        begin
            num_ok  = !digit_seen_reg && !num_neg_reg;
            upd_neg = 1'b1;
        end
        else if (is_digit)
        begin
            num_ok = !lead_zero_reg && !(!digit_seen_reg && digit == 4'd0 && num_neg_reg);
            if (!digit_seen_reg && digit == 4'd0)
            begin
                upd_lead = 1'b1;
            end
            if (!num_ovf_reg)
            begin
                if (num_prod > {4'd0, rcf_pkg::MAG_LIMIT})
                begin
                    upd_ovf = 1'b1;
                end
                else
                begin
                    upd_value = num_prod[63:0];
                end
            end
        end
    end

    assign num_good = digit_seen_reg && !num_ovf_reg
                      && !(!num_neg_reg && num_value_reg == rcf_pkg::MAG_LIMIT);
    assign arg_lim  = (arg_limit_reg > rcf_pkg::ARG_LIMIT_RESET)
                      ? rcf_pkg::ARG_LIMIT_RESET : arg_limit_reg;
    assign bulk_lim = (bulk_limit_reg > rcf_pkg::BULK_LIMIT_RESET)
                      ? rcf_pkg::BULK_LIMIT_RESET : bulk_limit_reg;
    assign args_dec    = args_left_reg - {{(rcf_pkg::ARG_LIMIT_W-1){1'b0}}, 1'b1};
    assign payload_dec = payload_left_reg - {{(rcf_pkg::BULK_LIMIT_W-1){1'b0}}, 1'b1};

    // parse step
    always_comb
    begin
        phase_next        = phase_reg;
        args_left_next    = args_left_reg;
        payload_left_next = payload_left_reg;
        num_value_next    = num_value_reg;
        num_neg_next      = num_neg_reg;
        num_ovf_next      = num_ovf_reg;
        digit_seen_next   = digit_seen_reg;
        lead_zero_next    = lead_zero_reg;
        cr_pending_next   = cr_pending_reg;
        res0              = '0;
        res1              = '0;
        res_count         = 2'd0;
        do_fail           = 1'b0;
        do_finish         = 1'b0;
        do_clear_num      = 1'b0;
        fail_code         = rcf_pkg::ERR_NONE;

        case (phase_reg)
            PH_HNUM, PH_BNUM:
            begin
                if (in_byte == rcf_pkg::CH_CR)
                begin
                    phase_next = (phase_reg == PH_HNUM) ? PH_HLF : PH_BLF;
                end
                else if (num_ok)
                begin
                    num_neg_next    = upd_neg;
                    num_ovf_next    = upd_ovf;
                    lead_zero_next  = upd_lead;
                    num_value_next  = upd_value;
                    digit_seen_next = digit_seen_reg || is_digit;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_NUMBER;
                end
            end
            PH_HLF:
            begin
                if (in_byte != rcf_pkg::CH_LF || !num_good)
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_NUMBER;
                end
                else if (num_neg_reg
                         || num_value_reg > {{(rcf_pkg::NUM_W-rcf_pkg::ARG_LIMIT_W){1'b0}},
                                             arg_lim})
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_COUNT_RANGE;
                end
                else
                begin
                    args_left_next = num_value_reg[rcf_pkg::ARG_LIMIT_W-1:0];
                    do_clear_num   = 1'b1;
                    if (num_value_reg == '0)
                    begin
                        res0.command_done = 1'b1;
                        res_count         = 2'd1;
                        phase_next        = PH_STAR;
                    end
                    else
                    begin
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_TYPE:
            begin
                if (in_byte == rcf_pkg::CH_DOLLAR)
                begin
                    do_clear_num = 1'b1;
                    phase_next   = PH_BNUM;
                end
                else if (in_byte == rcf_pkg::CH_PLUS)
                begin
                    cr_pending_next = 1'b0;
                    phase_next      = PH_TEXT;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_TYPE;
                end
            end
            PH_BLF:
            begin
                if (in_byte != rcf_pkg::CH_LF || !num_good)
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_NUMBER;
                end
                else if (num_neg_reg)
                begin
                    do_clear_num = 1'b1;
                    do_finish    = 1'b1;
                end
                else if (num_value_reg > {{(rcf_pkg::NUM_W-rcf_pkg::BULK_LIMIT_W){1'b0}},
                                          bulk_lim})
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_BULK_LONG;
                end
                else
                begin
                    payload_left_next = num_value_reg[rcf_pkg::BULK_LIMIT_W-1:0];
                    do_clear_num      = 1'b1;
                    phase_next        = (num_value_reg != '0) ? PH_PAY : PH_PCR;
                end
            end
            PH_PAY:
            begin
                res0.arg_byte     = in_byte;
                res0.byte_valid   = 1'b1;
                res_count         = 2'd1;
                payload_left_next = payload_dec;
                if (payload_dec == '0)
                begin
                    phase_next = PH_PCR;
                end
            end
            PH_PCR:
            begin
                if (in_byte == rcf_pkg::CH_CR)
                begin
                    phase_next = PH_PLF;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_NO_CRLF;
                end
            end
            PH_PLF:
            begin
                if (in_byte == rcf_pkg::CH_LF)
                begin
                    do_finish = 1'b1;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_NO_CRLF;
                end
            end
            PH_TEXT:
            begin
                if (cr_pending_reg)
                begin
                    if (in_byte == rcf_pkg::CH_LF)
                    begin
                        cr_pending_next = 1'b0;
                        do_finish       = 1'b1;
                    end
                    else if (in_byte == rcf_pkg::CH_CR)
                    begin
                        res0.arg_byte   = rcf_pkg::CH_CR;
                        res0.byte_valid = 1'b1;
                        res_count       = 2'd1;
                    end
                    else
                    begin
                        res0.arg_byte   = rcf_pkg::CH_CR;
                        res0.byte_valid = 1'b1;
                        res1.arg_byte   = in_byte;
                        res1.byte_valid = 1'b1;
                        res_count       = 2'd2;
                        cr_pending_next = 1'b0;
                    end
                end
                else if (in_byte == rcf_pkg::CH_CR)
                begin
                    cr_pending_next = 1'b1;
                end
                else
                begin
                    res0.arg_byte   = in_byte;
                    res0.byte_valid = 1'b1;
                    res_count       = 2'd1;
                end
            end
            default:
            begin
                if (in_byte == rcf_pkg::CH_STAR)
                begin
                    do_clear_num      = 1'b1;
                    args_left_next    = '0;
                    payload_left_next = '0;
                    cr_pending_next   = 1'b0;
                    phase_next        = PH_HNUM;
                end
                else
                begin
                    do_fail   = 1'b1;
                    fail_code = rcf_pkg::ERR_TYPE;
                end
            end
        endcase

        if (do_clear_num || do_fail)
        begin
            num_value_next  = '0;
            num_neg_next    = 1'b0;
            num_ovf_next    = 1'b0;
            digit_seen_next = 1'b0;
            lead_zero_next  = 1'b0;
        end

        if (do_finish)
        begin
            args_left_next    = args_dec;
            res0.arg_end      = 1'b1;
            res0.command_done = (args_dec == '0);
            res_count         = 2'd1;
            phase_next        = (args_dec == '0) ? PH_STAR : PH_TYPE;
        end

        if (do_fail)
        begin
            res0              = '0;
            res0.error_code   = fail_code;
            res_count         = 2'd1;
            phase_next        = PH_STAR;
            args_left_next    = '0;
            payload_left_next = '0;
            cr_pending_next   = 1'b0;
        end

        res0.last_of_run = (res_count == 2'd1);
        res1.last_of_run = 1'b1;
    end

    // parser state, limits and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_STAR;
            arg_limit_reg    <= rcf_pkg::ARG_LIMIT_RESET;
            bulk_limit_reg   <= rcf_pkg::BULK_LIMIT_RESET;
            args_left_reg    <= '0;
            payload_left_reg <= '0;
            num_value_reg    <= '0;
            num_neg_reg      <= 1'b0;
            num_ovf_reg      <= 1'b0;
            digit_seen_reg   <= 1'b0;
            lead_zero_reg    <= 1'b0;
            cr_pending_reg   <= 1'b0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            count_reg        <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    rcf_pkg::CFG_ARG_LIMIT:
                        arg_limit_reg <= cfg_data[rcf_pkg::ARG_LIMIT_W-1:0];
                    default:
                        bulk_limit_reg <= cfg_data;
                endcase
            end
            if (in_fire)
            begin
                phase_reg        <= phase_next;
                args_left_reg    <= args_left_next;
                payload_left_reg <= payload_left_next;
                num_value_reg    <= num_value_next;
                num_neg_reg      <= num_neg_next;
                num_ovf_reg      <= num_ovf_next;
                digit_seen_reg   <= digit_seen_next;
                lead_zero_reg    <= lead_zero_next;
                cr_pending_reg   <= cr_pending_next;
                wr_ptr_reg       <= wr_ptr_reg + res_count;
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_reg + (in_fire ? {1'b0, res_count} : 3'd0)
                         - {2'b00, out_fire};
        end
    end

    // result queue storage
    always_ff @(posedge clk)
    begin
        if (in_fire && res_count != 2'd0)
        begin
            queue_mem[wr_ptr_reg] <= res0;
        end
        if (in_fire && res_count == 2'd2)
        begin
            queue_mem[wr_ptr_reg + 2'd1] <= res1;
        end
    end

endmodule

`default_nettype wire

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and checking for the request command framer.
// A short directed byte sequence is followed by random command streams under
// several limit settings. Well-formed commands make up most of the stream; the
// rest are corrupted commands, junk bytes, bad numbers and limit violations.
// Every accepted result word is checked against an in-bench parser model or a
// directed table word, with random idling on both sides and one long output stall.
// ----------------------------------------------------------------------------

module tb;

    typedef enum logic [3:0] {
        P_STAR, P_HNUM, P_HLF, P_TYPE, P_BNUM, P_BLF, P_PAY, P_PCR, P_PLF, P_TEXT
    } parse_phase_t;

    typedef struct packed {
        logic [7:0]       b;
        logic             typed;
        rcf_pkg::result_t word;
    } stim_t;

    localparam rcf_pkg::result_t NO_WORD          = '0;
    localparam rcf_pkg::result_t ERR_TYPE_WORD    =
        {8'h00, 3'b000, rcf_pkg::ERR_TYPE, 1'b1};
    localparam rcf_pkg::result_t COUNT_RANGE_WORD =
        {8'h00, 3'b000, rcf_pkg::ERR_COUNT_RANGE, 1'b1};
    localparam rcf_pkg::result_t BULK_LONG_WORD   =
        {8'h00, 3'b000, rcf_pkg::ERR_BULK_LONG, 1'b1};
    localparam rcf_pkg::result_t DONE_WORD        =
        {8'h00, 3'b001, rcf_pkg::ERR_NONE, 1'b1};

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [7:0]       in_byte = 8'h00;
    logic             in_typed = 1'b0;
    rcf_pkg::result_t in_typed_word = '0;

    logic        out_valid;
    logic        out_ready;
    logic        rx_want = 1'b0;
    logic        hold_off = 1'b0;
    logic [7:0]  arg_byte;
    logic        byte_valid;
    logic        arg_end;
    logic        command_done;
    logic [2:0]  error_code;
    logic        last_of_run;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_index = 1'b0;
    logic [29:0] cfg_data = 30'd0;

    // parser model state
    parse_phase_t     ph = P_STAR;
    logic [20:0]      args_left = '0;
    logic [29:0]      pay_left = '0;
    logic [63:0]      num_val = '0;
    logic             num_neg = 1'b0;
    logic             num_ovf = 1'b0;
    logic [4:0]       n_digits = '0;
    logic             lead_zero = 1'b0;
    logic             cr_held = 1'b0;
    logic [20:0]      arg_limit_reg = rcf_pkg::ARG_LIMIT_RESET;
    logic [29:0]      bulk_limit_reg = rcf_pkg::BULK_LIMIT_RESET;
    rcf_pkg::result_t step_res [0:1];
    int               step_n;

    rcf_pkg::result_t pending_q [$];
    stim_t            stim_q [$];
    int               faults = 0;
    int               results_taken = 0;
    logic             tx_steady = 1'b0;
    logic             rx_steady = 1'b0;

    stim_t directed_tbl [0:28] = '{
        {8'hFF,              1'b1, ERR_TYPE_WORD},
        {rcf_pkg::CH_STAR,   1'b0, NO_WORD},
        {"4",                1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_LF,     1'b1, COUNT_RANGE_WORD},
        {rcf_pkg::CH_STAR,   1'b0, NO_WORD},
        {"3",                1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_LF,     1'b0, NO_WORD},
        {rcf_pkg::CH_PLUS,   1'b0, NO_WORD},
        {8'h00,              1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {8'hFF,              1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_LF,     1'b0, NO_WORD},
        {rcf_pkg::CH_DOLLAR, 1'b0, NO_WORD},
        {rcf_pkg::CH_MINUS,  1'b0, NO_WORD},
        {"1",                1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_LF,     1'b0, NO_WORD},
        {rcf_pkg::CH_DOLLAR, 1'b0, NO_WORD},
        {"5",                1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_LF,     1'b1, BULK_LONG_WORD},
        {rcf_pkg::CH_STAR,   1'b0, NO_WORD},
        {"0",                1'b0, NO_WORD},
        {rcf_pkg::CH_CR,     1'b0, NO_WORD},
        {rcf_pkg::CH_LF,     1'b1, DONE_WORD}
    };

    assign out_ready = rx_want && !hold_off;

    resp_command_framer_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_byte      (in_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .arg_byte     (arg_byte),
        .byte_valid   (byte_valid),
        .arg_end      (arg_end),
        .command_done (command_done),
        .error_code   (error_code),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function logic [63:0] arg_cap();
        return (arg_limit_reg > rcf_pkg::ARG_COUNT_CAP)
               ? 64'(rcf_pkg::ARG_COUNT_CAP) : 64'(arg_limit_reg);
    endfunction

    function logic [63:0] bulk_cap();
        return (bulk_limit_reg > rcf_pkg::BULK_LENGTH_CAP)
               ? 64'(rcf_pkg::BULK_LENGTH_CAP) : 64'(bulk_limit_reg);
    endfunction

    function void add_word(logic [7:0] b, logic v, logic e, logic d, logic [2:0] err);
        if (step_n < 2)
        begin
            step_res[step_n] = {b, v, e, d, err, 1'b0};
            step_n++;
        end
    endfunction

    function void clear_num();
        num_val = '0;
        num_neg = 1'b0;
        num_ovf = 1'b0;
        n_digits = '0;
        lead_zero = 1'b0;
    endfunction

    function void abort_parse(logic [2:0] err);
        add_word(8'h00, 1'b0, 1'b0, 1'b0, err);
        ph = P_STAR;
        args_left = '0;
        pay_left = '0;
        cr_held = 1'b0;
        clear_num();
    endfunction

    function logic take_num_char(logic [7:0] b);
        logic [63:0] d;
        if (b == rcf_pkg::CH_MINUS)
        begin
            if (n_digits != 0 || num_neg)
                return 1'b0;
            num_neg = 1'b1;
            return 1'b1;
        end
        if (b < rcf_pkg::CH_ZERO || b > rcf_pkg::CH_NINE)
            return 1'b0;
        d = {56'd0, b - rcf_pkg::CH_ZERO};
        if (lead_zero)
            return 1'b0;
        if (n_digits == 0 && d == 0)
        begin
            if (num_neg)
                return 1'b0;
            lead_zero = 1'b1;
        end
        if (!num_ovf)
        begin
            if (num_val > (rcf_pkg::MAG_LIMIT - d) / 10)
                num_ovf = 1'b1;
            else
                num_val = num_val * 10 + d;
        end
        if (n_digits < 31)
            n_digits++;
        return 1'b1;
    endfunction

    function logic num_ok();
        return (n_digits != 0) && !num_ovf
               && (num_neg || num_val <= rcf_pkg::MAG_LIMIT - 64'd1);
    endfunction

    function void close_arg();
        args_left = args_left - 21'd1;
        add_word(8'h00, 1'b0, 1'b1, args_left == 0, rcf_pkg::ERR_NONE);
        ph = (args_left == 0) ? P_STAR : P_TYPE;
    endfunction

    // results caused by one accepted byte land in step_res
    function void frame_byte(logic [7:0] b);
        step_n = 0;
        case (ph)
            P_HNUM, P_BNUM:
            begin
                if (b == rcf_pkg::CH_CR)
                    ph = (ph == P_HNUM) ? P_HLF : P_BLF;
                else if (!take_num_char(b))
                    abort_parse(rcf_pkg::ERR_NUMBER);
            end
            P_HLF:
            begin
                if (b != rcf_pkg::CH_LF || !num_ok())
                    abort_parse(rcf_pkg::ERR_NUMBER);
                else if (num_neg || num_val > arg_cap())
                    abort_parse(rcf_pkg::ERR_COUNT_RANGE);
                else
                begin
                    args_left = num_val[20:0];
                    clear_num();
                    if (args_left == 0)
                    begin
                        add_word(8'h00, 1'b0, 1'b0, 1'b1, rcf_pkg::ERR_NONE);
                        ph = P_STAR;
                    end
                    else
                        ph = P_TYPE;
                end
            end
            P_TYPE:
            begin
                if (b == rcf_pkg::CH_DOLLAR)
                begin
                    clear_num();
                    ph = P_BNUM;
                end
                else if (b == rcf_pkg::CH_PLUS)
                begin
                    cr_held = 1'b0;
                    ph = P_TEXT;
                end
                else
                    abort_parse(rcf_pkg::ERR_TYPE);
            end
            P_BLF:
            begin
                if (b != rcf_pkg::CH_LF || !num_ok())
                    abort_parse(rcf_pkg::ERR_NUMBER);
                else if (num_neg)
                begin
                    clear_num();
                    close_arg();
                end
                else if (num_val > bulk_cap())
                    abort_parse(rcf_pkg::ERR_BULK_LONG);
                else
                begin
                    pay_left = num_val[29:0];
                    clear_num();
                    ph = (pay_left != 0) ? P_PAY : P_PCR;
                end
            end
            P_PAY:
            begin
                add_word(b, 1'b1, 1'b0, 1'b0, rcf_pkg::ERR_NONE);
                pay_left = pay_left - 30'd1;
                if (pay_left == 0)
                    ph = P_PCR;
            end
            P_PCR:
            begin
                if (b == rcf_pkg::CH_CR)
                    ph = P_PLF;
                else
                    abort_parse(rcf_pkg::ERR_NO_CRLF);
            end
            P_PLF:
            begin
                if (b == rcf_pkg::CH_LF)
                    close_arg();
                else
                    abort_parse(rcf_pkg::ERR_NO_CRLF);
            end
            P_TEXT:
            begin
                if (cr_held)
                begin
                    if (b == rcf_pkg::CH_LF)
                    begin
                        cr_held = 1'b0;
                        close_arg();
                    end
                    else if (b == rcf_pkg::CH_CR)
                        add_word(rcf_pkg::CH_CR, 1'b1, 1'b0, 1'b0, rcf_pkg::ERR_NONE);
                    else
                    begin
                        add_word(rcf_pkg::CH_CR, 1'b1, 1'b0, 1'b0, rcf_pkg::ERR_NONE);
                        add_word(b, 1'b1, 1'b0, 1'b0, rcf_pkg::ERR_NONE);
                        cr_held = 1'b0;
                    end
                end
                else if (b == rcf_pkg::CH_CR)
                    cr_held = 1'b1;
                else
                    add_word(b, 1'b1, 1'b0, 1'b0, rcf_pkg::ERR_NONE);
            end
            default:
            begin
                if (b == rcf_pkg::CH_STAR)
                begin
                    clear_num();
                    args_left = '0;
                    pay_left = '0;
                    cr_held = 1'b0;
                    ph = P_HNUM;
                end
                else
                    abort_parse(rcf_pkg::ERR_TYPE);
            end
        endcase
        if (step_n > 0)
            step_res[step_n - 1].last_of_run = 1'b1;
    endfunction

    // stream generation
    function void push_byte(logic [7:0] b);
        stim_q.push_back({b, 1'b0, NO_WORD});
    endfunction

    function void push_crlf();
        push_byte(rcf_pkg::CH_CR);
        push_byte(rcf_pkg::CH_LF);
    endfunction

    function void push_decimal(logic [63:0] mag, logic neg);
        logic [7:0] digs [0:19];
        int         n;
        n = 0;
        if (neg)
            push_byte(rcf_pkg::CH_MINUS);
        do
        begin
            digs[n] = rcf_pkg::CH_ZERO + 8'(mag % 10);
            mag = mag / 10;
            n++;
        end
        while (mag != 0);
        for (int i = n - 1; i >= 0; i--)
            push_byte(digs[i]);
    endfunction

    function void push_header1();
        push_byte(rcf_pkg::CH_STAR);
        push_decimal(64'd1, 1'b0);
        push_crlf();
    endfunction

    function void push_text();
        logic [7:0] b;
        logic [7:0] prev;
        int         n;
        n = $urandom_range(0, 8);
        prev = 8'h00;
        push_byte(rcf_pkg::CH_PLUS);
        for (int i = 0; i < n; i++)
        begin
            b = ($urandom_range(0, 3) == 0) ? rcf_pkg::CH_CR : 8'($urandom_range(0, 255));
            if (prev == rcf_pkg::CH_CR && b == rcf_pkg::CH_LF)
                b = 8'h41;
            push_byte(b);
            prev = b;
        end
        push_crlf();
    endfunction

    function void push_bulk();
        logic [63:0] hi;
        logic [63:0] len;
        int          sel;
        push_byte(rcf_pkg::CH_DOLLAR);
        sel = $urandom_range(0, 15);
        hi = bulk_cap();
        if (sel < 2)
        begin
            push_decimal((sel == 0) ? rcf_pkg::MAG_LIMIT : 64'($urandom_range(1, 40)), 1'b1);
            push_crlf();
        end
        else
        begin
            if (sel == 15)
                len = (hi < 40) ? hi : 64'd40;
            else
                len = 64'($urandom_range(0, (hi < 8) ? int'(hi) : 8));
            push_decimal(len, 1'b0);
            push_crlf();
            repeat (len)
                push_byte(8'($urandom_range(0, 255)));
            push_crlf();
        end
    endfunction

    function void gen_command();
        logic [63:0] hi;
        int unsigned cnt;
        hi = arg_cap();
        cnt = $urandom_range(0, (hi < 4) ? int'(hi) : 4);
        push_byte(rcf_pkg::CH_STAR);
        push_decimal(64'(cnt), 1'b0);
        push_crlf();
        repeat (cnt)
            if ($urandom_range(0, 1) == 1)
                push_bulk();
            else
                push_text();
    endfunction

    function void push_bad_number();
        logic [7:0] c;
        case ($urandom_range(0, 8))
            0:
            begin
                push_byte(rcf_pkg::CH_MINUS);
                push_byte(rcf_pkg::CH_ZERO);
            end
            1:
            begin
                push_byte(rcf_pkg::CH_ZERO);
                push_byte("1");
            end
            2:
            begin
                push_byte(rcf_pkg::CH_MINUS);
                push_byte(rcf_pkg::CH_MINUS);
                push_byte("1");
            end
            3:
            begin
                push_byte("1");
                push_byte(rcf_pkg::CH_MINUS);
            end
            4: ;
            5: push_decimal(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
            6: push_decimal(rcf_pkg::MAG_LIMIT, 1'b0);
            7: push_decimal(rcf_pkg::MAG_LIMIT, 1'b1);
            default:
            begin
                c = 8'($urandom_range(0, 255));
                if ((c >= rcf_pkg::CH_ZERO && c <= rcf_pkg::CH_NINE)
                    || c == rcf_pkg::CH_MINUS || c == rcf_pkg::CH_CR)
                    c = 8'h78;
                push_byte("1");
                push_byte(c);
            end
        endcase
    endfunction

    function void gen_broken();
        stim_t s;
        int    first;
        int    pick;
        case ($urandom_range(0, 7))
            0:
            begin
                first = stim_q.size();
                gen_command();
                pick = $urandom_range(first, stim_q.size() - 1);
                s = stim_q[pick];
                s.b = 8'($urandom_range(0, 255));
                stim_q[pick] = s;
            end
            1:
            begin
                pick = $urandom_range(0, 255);
                push_byte((8'(pick) == rcf_pkg::CH_STAR) ? 8'h00 : 8'(pick));
            end
            2:
            begin
                push_byte(rcf_pkg::CH_STAR);
                push_bad_number();
                push_crlf();
            end
            3:
            begin
                push_byte(rcf_pkg::CH_STAR);
                if ($urandom_range(0, 1) == 1)
                    push_decimal(arg_cap() + 64'd1 + 64'($urandom_range(0, 2)), 1'b0);
                else
                    push_decimal(64'($urandom_range(1, 9)), 1'b1);
                push_crlf();
            end
            4:
            begin
                push_header1();
                pick = $urandom_range(0, 255);
                if (8'(pick) == rcf_pkg::CH_DOLLAR || 8'(pick) == rcf_pkg::CH_PLUS)
                    pick = 0;
                push_byte(8'(pick));
            end
            5:
            begin
                push_header1();
                push_byte(rcf_pkg::CH_DOLLAR);
                push_decimal(bulk_cap() + 64'd1 + 64'($urandom_range(0, 2)), 1'b0);
                push_crlf();
            end
            6:
            begin
                push_header1();
                push_byte(rcf_pkg::CH_DOLLAR);
                push_decimal(64'd1, 1'b0);
                push_crlf();
                push_byte(8'($urandom_range(0, 255)));
                pick = $urandom_range(0, 255);
                if ($urandom_range(0, 1) == 1)
                    push_byte((8'(pick) == rcf_pkg::CH_CR) ? 8'h00 : 8'(pick));
                else
                begin
                    push_byte(rcf_pkg::CH_CR);
                    push_byte((8'(pick) == rcf_pkg::CH_LF) ? 8'h00 : 8'(pick));
                end
            end
            default:
            begin
                push_byte(rcf_pkg::CH_STAR);
                push_byte(rcf_pkg::CH_ZERO + 8'($urandom_range(1, 9)));
                push_byte(rcf_pkg::CH_CR);
                pick = $urandom_range(0, 255);
                push_byte((8'(pick) == rcf_pkg::CH_LF) ? 8'h00 : 8'(pick));
            end
        endcase
    endfunction

    task automatic note_fault(string what, rcf_pkg::result_t want, rcf_pkg::result_t got);
        faults++;
        if (faults <= 10)
        begin
            $write("%s at %0t: want byte=%02h v=%b end=%b done=%b err=%0d last=%b, ",
                what, $time,
                want.arg_byte, want.byte_valid, want.arg_end, want.command_done,
                want.error_code, want.last_of_run);
            $display("got byte=%02h v=%b end=%b done=%b err=%0d last=%b",
                got.arg_byte, got.byte_valid, got.arg_end, got.command_done,
                got.error_code, got.last_of_run);
        end
    endtask

    always @(posedge clk)
    begin : scoreboard
        rcf_pkg::result_t got;
        rcf_pkg::result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                frame_byte(in_byte);
                if (in_typed)
                    pending_q.push_back(in_typed_word);
                else
                    for (int k = 0; k < step_n; k++)
                        pending_q.push_back(step_res[k]);
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == rcf_pkg::CFG_ARG_LIMIT)
                    arg_limit_reg = cfg_data[20:0];
                else
                    bulk_limit_reg = cfg_data;
            end
            if (out_valid && out_ready)
            begin
                got = {arg_byte, byte_valid, arg_end, command_done, error_code, last_of_run};
                results_taken++;
                if (pending_q.size() == 0)
                    note_fault("unexpected word", NO_WORD, got);
                else
                begin
                    want = pending_q.pop_front();
                    if (got !== want)
                        note_fault("mismatch", want, got);
                end
            end
        end
    end

    task automatic send_queued();
        stim_t s;
        int    gap;
        while (stim_q.size() != 0)
        begin
            s = stim_q.pop_front();
            if ($urandom_range(0, 49) == 0)
                tx_steady = !tx_steady;
            gap = tx_steady ? 0 : $urandom_range(0, 9);
            repeat (gap)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            @(negedge clk);
            in_valid <= 1'b1;
            in_byte <= s.b;
            in_typed <= s.typed;
            in_typed_word <= s.word;
            do
                @(posedge clk);
            while (!in_ready);
        end
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic cfg_write(logic [0:0] idx, logic [29:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        while (pending_q.size() != 0)
            @(posedge clk);
        // a byte with no result may still be in flight
        repeat (4) @(posedge clk);
    endtask

    task automatic run_phase(logic [29:0] arg_word, logic [29:0] bulk_word, int n_bytes);
        cfg_write(rcf_pkg::CFG_ARG_LIMIT, arg_word);
        cfg_write(rcf_pkg::CFG_BULK_LIMIT, bulk_word);
        while (stim_q.size() < n_bytes)
            if ($urandom_range(0, 99) < 75)
                gen_command();
            else
                gen_broken();
        send_queued();
        settle();
    endtask

    initial
    begin : receiver
        int stall;
        forever
        begin
            if ($urandom_range(0, 49) == 0)
                rx_steady = !rx_steady;
            stall = rx_steady ? 0 : $urandom_range(0, 9);
            repeat (stall)
            begin
                @(negedge clk);
                rx_want <= 1'b0;
            end
            @(negedge clk);
            rx_want <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
        end
    end

    // long output stall so the result queue fills and input backs up
    initial
    begin : backpressure
        wait (results_taken >= 60);
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (300) @(negedge clk);
        hold_off <= 1'b0;
    end

    initial
    begin : watchdog
        #3_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : main
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        cfg_write(rcf_pkg::CFG_ARG_LIMIT, 30'd3);
        cfg_write(rcf_pkg::CFG_BULK_LIMIT, 30'd4);
        foreach (directed_tbl[i])
            stim_q.push_back(directed_tbl[i]);
        send_queued();
        settle();

        run_phase(30'h3FFF_FFFF, 30'h3FFF_FFFF, 220);
        run_phase(30'd0, 30'd0, 140);
        run_phase(30'($urandom_range(1, 4)), 30'($urandom_range(1, 12)), 180);
        run_phase(30'(rcf_pkg::ARG_COUNT_CAP), 30'(rcf_pkg::BULK_LENGTH_CAP), 180);
        run_phase(30'($urandom), 30'($urandom), 180);

        repeat (10) @(posedge clk);
        if (faults == 0 && pending_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
design/rcf_pkg.sv
design/resp_command_framer_top.sv
dv/tb.sv
